@@ design/klock_pkg.sv @@
// Shared types and constants of the keypad code lock.
package klock_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int CODE_DIGITS = 4;

    localparam int DIGIT_W   = 4;
    localparam int ADDR_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W     = $clog2(CODE_DIGITS + 1);
    localparam int DIG_IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

    localparam logic [DIGIT_W-1:0] NO_DIGIT  = DIGIT_W'(10);
    localparam logic [DIGIT_W-1:0] MAX_DIGIT = DIGIT_W'(9);

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    localparam int STATUS_W = 3;
    localparam int OUT_LEN_W = 3;
    localparam int OUT_TOTAL_W = 4;

    typedef enum logic [S_TUSER_W-1:0] {
        ACT_DIGIT  = 2'd0,
        ACT_VERIFY = 2'd1,
        ACT_ENROLL = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_TAKEN     = 3'd0,
        ST_IGNORED   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_GRANTED   = 3'd3,
        ST_DENIED    = 3'd4,
        ST_STORED    = 3'd5,
        ST_DUPLICATE = 3'd6,
        ST_FULL      = 3'd7
    } status_t;

    typedef struct packed {
        logic [LEN_W-1:0]                  length;
        logic [CODE_DIGITS-1:0][DIGIT_W-1:0] digits;
    } slot_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        slot_t             data;
    } tbl_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } tbl_rd_t;

endpackage

@@ design/klock_table.sv @@
// Code table storage: one write port, one read port with registered data.
module klock_table (
    input  logic              aclk,
    input  klock_pkg::tbl_wr_t wr,
    input  klock_pkg::tbl_rd_t rd,
    output klock_pkg::slot_t   rd_data
);
    import klock_pkg::*;

    slot_t mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

@@ design/keypad_code_lock_with_code_table_top.sv @@
// Top level of the keypad code lock with its table of enrolled codes.
//
// Input beats carry one decoded key event: s_tuser holds the key kind
// (digit, verify, enroll) and s_tdata the digit. Each input beat yields
// exactly one result beat on the m_ channel with the status, the entry
// length after the key and the number of stored codes.
//
// A digit key, an unused key or a verify or enroll with an empty entry goes
// straight to the done state, and s_tready is back in the cycle in which its
// result appears in the output register. Any other verify or enroll key
// walks the code table, one read per cycle through its single read port,
// and a match ends the walk early.
// One key is in flight at a time; s_tready rises again once the result has
// moved to the output register, so the next key is taken while a result
// still waits for m_tready.
// A stalled receiver holds the result in the output register; a finished
// key waits for that register before the next key is accepted.
// Reset (aresetn low, synchronous) clears the entry, the code count and
// the output valid at once; only slots below the count are ever read.
module keypad_code_lock_with_code_table_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] digit, [7:4] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [2:0] status, [5:3] entered_length,
                                   // [9:6] stored_total, [15:10] zero
);
    import klock_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CODE_DIGITS-1:0][DIGIT_W-1:0] entry_digits_reg, entry_digits_next;
    logic [LEN_W-1:0] entry_count_reg, entry_count_next;
    logic [CNT_W-1:0] code_count_reg, code_count_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             is_enroll_reg, is_enroll_next;
    status_t          pend_status_reg, pend_status_next;
    logic             m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    tbl_wr_t wr;
    tbl_rd_t rd;
    slot_t   rd_data;

    logic [DIGIT_W-1:0] digit;
    logic accept;
    logic match, hit, issue, out_free;

    klock_table u_table (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign digit    = s_tdata[DIGIT_W-1:0];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign match = (rd_data.length == entry_count_reg) &&
                   (rd_data.digits == entry_digits_reg);
    assign hit   = cmp_valid_reg && match;
    assign issue = (k_reg < code_count_reg);

    always_comb begin
        state_next        = state_reg;
        entry_digits_next = entry_digits_reg;
        entry_count_next  = entry_count_reg;
        code_count_next   = code_count_reg;
        k_next            = k_reg;
        cmp_valid_next    = cmp_valid_reg;
        is_enroll_next    = is_enroll_reg;
        pend_status_next  = pend_status_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;
        wr                = '0;
        rd                = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        ACT_DIGIT: begin
                            state_next = S_DONE;
                            if (digit <= MAX_DIGIT &&
                                entry_count_reg < LEN_W'(CODE_DIGITS)) begin
                                entry_digits_next[entry_count_reg[DIG_IDX_W-1:0]] = digit;
                                entry_count_next = entry_count_reg + LEN_W'(1);
                                pend_status_next = ST_TAKEN;
                            end else begin
                                pend_status_next = ST_IGNORED;
                            end
                        end
                        ACT_VERIFY, ACT_ENROLL: begin
                            is_enroll_next = (s_tuser == ACT_ENROLL);
                            if (entry_count_reg == '0) begin
                                pend_status_next = ST_EMPTY;
                                state_next       = S_DONE;
                            end else begin
                                k_next         = '0;
                                cmp_valid_next = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        default: begin
                            pend_status_next = ST_IGNORED;
                            state_next       = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit || (!issue && !cmp_valid_reg)) begin
                    // walk over: decide, clear the entry, store if new and the table has room
                    cmp_valid_next = 1'b0;
                    state_next     = S_DONE;
                    if (!is_enroll_reg) begin
                        pend_status_next = hit ? ST_GRANTED : ST_DENIED;
                    end else if (hit) begin
                        pend_status_next = ST_DUPLICATE;
                    end else if (code_count_reg == CNT_W'(TABLE_DEPTH)) begin
                        pend_status_next = ST_FULL;
                    end else begin
                        wr.en            = 1'b1;
                        wr.addr          = code_count_reg[ADDR_W-1:0];
                        wr.data.length   = entry_count_reg;
                        wr.data.digits   = entry_digits_reg;
                        code_count_next  = code_count_reg + CNT_W'(1);
                        pend_status_next = ST_STORED;
                    end
                    for (int i = 0; i < CODE_DIGITS; i++) begin
                        entry_digits_next[i] = NO_DIGIT;
                    end
                    entry_count_next = '0;
                end else begin
                    // keep one read in flight per cycle
                    rd.en          = issue;
                    rd.addr        = k_reg[ADDR_W-1:0];
                    cmp_valid_next = issue;
                    if (issue) begin
                        k_next = k_reg + CNT_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (pend_status_reg == ST_EMPTY) begin
                    // empty verify or enroll still clears the entry
                    for (int i = 0; i < CODE_DIGITS; i++) begin
                        entry_digits_next[i] = NO_DIGIT;
                    end
                end
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_tdata_next = '0;
                    m_tdata_next[STATUS_W-1:0] = pend_status_reg;
                    m_tdata_next[STATUS_W +: OUT_LEN_W] = OUT_LEN_W'(entry_count_reg);
                    m_tdata_next[STATUS_W + OUT_LEN_W +: OUT_TOTAL_W] =
                        OUT_TOTAL_W'(code_count_reg);
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            for (int i = 0; i < CODE_DIGITS; i++) begin
                entry_digits_reg[i] <= NO_DIGIT;
            end
            entry_count_reg <= '0;
            code_count_reg  <= '0;
            cmp_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            entry_digits_reg <= entry_digits_next;
            entry_count_reg  <= entry_count_next;
            code_count_reg   <= code_count_next;
            cmp_valid_reg    <= cmp_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg           <= k_next;
        is_enroll_reg   <= is_enroll_next;
        pend_status_reg <= pend_status_next;
        m_tdata_reg     <= m_tdata_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ design/klock_checker.sv @@
// Port-level checks of the keypad code lock, bound to the top level.
module klock_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import klock_pkg::*;

    // hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9:6] <= 4'(TABLE_DEPTH))
        else $error("stored total beyond table depth");

    // verify and enroll always leave an empty entry
    a_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != ST_TAKEN) && (m_tdata[2:0] != ST_IGNORED)
        |-> m_tdata[5:3] == 3'd0)
        else $error("entry not cleared after verify or enroll");

    a_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == ST_TAKEN) |-> m_tdata[5:3] != 3'd0)
        else $error("digit taken with empty entry");

endmodule

bind keypad_code_lock_with_code_table_top klock_checker u_klock_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
